### hw/rtl/pfs_pkg.sv
`default_nettype none

package pfs_pkg;

    // configuration port
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_FEC_CODE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CRC_ENABLE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DST_CALL   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DST_SUB_ID = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ORG_CALL   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ORG_SUB_ID = 3'd5;

    localparam logic [47:0] CALLSIGN_RESET = 48'h2020_2020_2020;

    // framing constants
    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [4:0]  SCR_INIT  = 5'h1F;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;

    // header is 19 bytes: preamble, sync x3, fec type, two 7-byte addresses
    localparam int IDX_W = 5;
    localparam logic [IDX_W-1:0] HDR_LAST = 5'd18;
    localparam logic [IDX_W-1:0] CRC_LAST = 5'd3;

    // byte source select
    localparam logic [1:0] SEL_FLAG = 2'd0;
    localparam logic [1:0] SEL_HDR  = 2'd1;
    localparam logic [1:0] SEL_PAY  = 2'd2;
    localparam logic [1:0] SEL_CRC  = 2'd3;

    typedef struct packed {
        logic [7:0]  fec_code;
        logic        crc_enable;
        logic [47:0] dst_call;
        logic [3:0]  dst_sub_id;
        logic [47:0] org_call;
        logic [3:0]  org_sub_id;
    } cfg_t;

    typedef struct packed {
        logic             load;
        logic             emit;
        logic [1:0]       sel;
        logic [IDX_W-1:0] idx;
        logic             frame_end;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

### hw/rtl/pfs_regs.sv
`default_nettype none

module pfs_regs
    import pfs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_FEC_CODE:   cfg_next.fec_code   = pwdata[7:0];
                REG_CRC_ENABLE: cfg_next.crc_enable = pwdata[0];
                REG_DST_CALL:   cfg_next.dst_call   = pwdata[47:0];
                REG_DST_SUB_ID: cfg_next.dst_sub_id = pwdata[3:0];
                REG_ORG_CALL:   cfg_next.org_call   = pwdata[47:0];
                REG_ORG_SUB_ID: cfg_next.org_sub_id = pwdata[3:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FEC_CODE:   prdata = {56'd0, cfg_reg.fec_code};
            REG_CRC_ENABLE: prdata = {63'd0, cfg_reg.crc_enable};
            REG_DST_CALL:   prdata = {16'd0, cfg_reg.dst_call};
            REG_DST_SUB_ID: prdata = {60'd0, cfg_reg.dst_sub_id};
            REG_ORG_CALL:   prdata = {16'd0, cfg_reg.org_call};
            REG_ORG_SUB_ID: prdata = {60'd0, cfg_reg.org_sub_id};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fec_code   <= 8'd0;
            cfg_reg.crc_enable <= 1'b1;
            cfg_reg.dst_call   <= CALLSIGN_RESET;
            cfg_reg.dst_sub_id <= 4'd0;
            cfg_reg.org_call   <= CALLSIGN_RESET;
            cfg_reg.org_sub_id <= 4'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### hw/rtl/pfs_ctrl.sv
`default_nettype none

module pfs_ctrl
    import pfs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire logic  last_of_frame,
    input  wire logic  crc_enable,
    input  stat_t      stat,
    output cmd_t       cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_OPEN  = 3'd1;
    localparam logic [2:0] S_HDR   = 3'd2;
    localparam logic [2:0] S_PAY   = 3'd3;
    localparam logic [2:0] S_CRC   = 3'd4;
    localparam logic [2:0] S_CLOSE = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             in_frame_reg, in_frame_next;
    logic             last_reg, last_next;
    logic             accept;
    logic             emit;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign emit     = (state_reg != S_IDLE) && stat.out_free;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        in_frame_next = in_frame_reg;
        last_next     = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // a mark on the opening byte does not close the frame
                    last_next     = last_of_frame && in_frame_reg;
                    in_frame_next = 1'b1;
                    state_next    = in_frame_reg ? S_PAY : S_OPEN;
                end
            end
            S_OPEN:
            begin
                if (emit)
                begin
                    cnt_next   = '0;
                    state_next = S_HDR;
                end
            end
            S_HDR:
            begin
                if (emit)
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                    if (cnt_reg == HDR_LAST)
                    begin
                        state_next = S_PAY;
                    end
                end
            end
            S_PAY:
            begin
                if (emit)
                begin
                    cnt_next = '0;
                    if (!last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (crc_enable)
                    begin
                        state_next = S_CRC;
                    end
                    else
                    begin
                        state_next = S_CLOSE;
                    end
                end
            end
            S_CRC:
            begin
                if (emit)
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                    if (cnt_reg == CRC_LAST)
                    begin
                        state_next = S_CLOSE;
                    end
                end
            end
            S_CLOSE:
            begin
                if (emit)
                begin
                    in_frame_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.load      = accept;
        cmd.emit      = emit;
        cmd.idx       = cnt_reg;
        cmd.frame_end = (state_reg == S_CLOSE);
        case (state_reg)
            S_HDR:   cmd.sel = SEL_HDR;
            S_PAY:   cmd.sel = SEL_PAY;
            S_CRC:   cmd.sel = SEL_CRC;
            default: cmd.sel = SEL_FLAG;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            in_frame_reg <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            in_frame_reg <= in_frame_next;
            last_reg     <= last_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pfs_dp.sv
`default_nettype none

module pfs_dp
    import pfs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] payload_byte,
    input  cfg_t            cfg,
    input  cmd_t            cmd,
    output stat_t           stat,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [9:0] line_bits,
    output logic      [3:0] bit_count,
    output logic            frame_done
);

    // byte-parallel reflected crc-32
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int j = 0; j < 8; j++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // additive five-bit scrambler, feedback from bits 4 and 0, msb first; returns {next state, data}
    function automatic logic [12:0] scramble(input logic [4:0] s_in, input logic [7:0] b);
        logic [4:0] s;
        logic [7:0] r;
        logic       fb;
        s = s_in;
        r = '0;
        for (int i = 7; i >= 0; i--)
        begin
            fb   = s[4] ^ s[0];
            s    = {s[3:0], fb};
            r[i] = b[i] ^ fb;
        end
        return {s, r};
    endfunction

    // zero insertion after five ones; returns {ones, count, bits}
    function automatic logic [16:0] stuff(input logic [2:0] ones_in, input logic [7:0] b);
        logic [9:0] bits;
        logic [3:0] pos;
        logic [2:0] ones;
        bits = '0;
        pos  = '0;
        ones = ones_in;
        for (int i = 7; i >= 0; i--)
        begin
            bits[pos] = b[i];
            pos = pos + 4'd1;
            if (b[i])
            begin
                ones = ones + 3'd1;
                if (ones >= 3'd5)
                begin
                    pos  = pos + 4'd1;
                    ones = '0;
                end
            end
            else
            begin
                ones = '0;
            end
        end
        return {ones, pos, bits};
    endfunction

    function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] idx, input cfg_t c);
        logic [7:0] h;
        case (idx)
            5'd0:    h = 8'h55;
            5'd1:    h = 8'hF1;
            5'd2:    h = 8'h5E;
            5'd3:    h = 8'h48;
            5'd4:    h = c.fec_code;
            5'd5:    h = {c.dst_call[46:40], 1'b0};
            5'd6:    h = {c.dst_call[38:32], 1'b0};
            5'd7:    h = {c.dst_call[30:24], 1'b0};
            5'd8:    h = {c.dst_call[22:16], 1'b0};
            5'd9:    h = {c.dst_call[14:8], 1'b0};
            5'd10:   h = {c.dst_call[6:0], 1'b0};
            5'd11:   h = {3'd0, c.dst_sub_id, 1'b0};
            5'd12:   h = {c.org_call[46:40], 1'b0};
            5'd13:   h = {c.org_call[38:32], 1'b0};
            5'd14:   h = {c.org_call[30:24], 1'b0};
            5'd15:   h = {c.org_call[22:16], 1'b0};
            5'd16:   h = {c.org_call[14:8], 1'b0};
            5'd17:   h = {c.org_call[6:0], 1'b0};
            5'd18:   h = {3'd0, c.org_sub_id, 1'b1};
            default: h = 8'h00;
        endcase
        return h;
    endfunction

    logic [7:0]  byte_reg;
    logic [4:0]  scr_reg, scr_next;
    logic [31:0] crc_reg, crc_next;
    logic [2:0]  ones_reg, ones_next;
    logic        out_valid_reg, out_valid_next;
    logic [9:0]  line_bits_reg, line_bits_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic        frame_done_reg, frame_done_next;

    logic [12:0] scr_res;
    logic [31:0] crc_out;
    logic [7:0]  tx_byte;
    logic [16:0] stf;

    assign stat.out_free = !out_valid_reg || out_ready;

    assign scr_res = scramble(scr_reg, byte_reg);
    assign crc_out = crc_reg ^ CRC_INIT;

    always_comb
    begin
        case (cmd.sel)
            SEL_HDR: tx_byte = hdr_byte(cmd.idx, cfg);
            SEL_PAY: tx_byte = scr_res[7:0];
            SEL_CRC:
            begin
                case (cmd.idx[1:0])
                    2'd0:    tx_byte = crc_out[7:0];
                    2'd1:    tx_byte = crc_out[15:8];
                    2'd2:    tx_byte = crc_out[23:16];
                    default: tx_byte = crc_out[31:24];
                endcase
            end
            default: tx_byte = FLAG_BYTE;
        endcase
    end

    assign stf = stuff(ones_reg, tx_byte);

    always_comb
    begin
        scr_next        = scr_reg;
        crc_next        = crc_reg;
        ones_next       = ones_reg;
        line_bits_next  = line_bits_reg;
        bit_count_next  = bit_count_reg;
        frame_done_next = frame_done_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        if (cmd.emit)
        begin
            out_valid_next  = 1'b1;
            frame_done_next = cmd.frame_end;
            if (cmd.sel == SEL_FLAG)
            begin
                // raw flag, msb first; opens or closes the frame
                for (int i = 0; i < 8; i++)
                begin
                    line_bits_next[i] = FLAG_BYTE[7-i];
                end
                line_bits_next[9:8] = 2'b00;
                bit_count_next      = 4'd8;
                ones_next           = '0;
                scr_next            = SCR_INIT;
                crc_next            = CRC_INIT;
            end
            else
            begin
                line_bits_next = stf[9:0];
                bit_count_next = stf[13:10];
                ones_next      = stf[16:14];
                if (cmd.sel != SEL_CRC)
                begin
                    crc_next = crc_byte(crc_reg, tx_byte);
                end
                if (cmd.sel == SEL_PAY)
                begin
                    scr_next = scr_res[12:8];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= payload_byte;
        end
        line_bits_reg <= line_bits_next;
        bit_count_reg <= bit_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_reg        <= SCR_INIT;
            crc_reg        <= CRC_INIT;
            ones_reg       <= '0;
            out_valid_reg  <= 1'b0;
            frame_done_reg <= 1'b0;
        end
        else
        begin
            scr_reg        <= scr_next;
            crc_reg        <= crc_next;
            ones_reg       <= ones_next;
            out_valid_reg  <= out_valid_next;
            frame_done_reg <= frame_done_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_bits  = line_bits_reg;
    assign bit_count  = bit_count_reg;
    assign frame_done = frame_done_reg;

endmodule

`default_nettype wire

### hw/rtl/packet_framer_scramble_crc_stuff.sv
// channel   | handshake          | payload
// ----------+--------------------+-------------------------------------------
// input     | in_valid/in_ready  | payload_byte[7:0], last_of_frame
// output    | out_valid/out_ready| line_bits[9:0], bit_count[3:0], frame_done
// config    | apb psel/penable   | paddr[5:0], pwdata/prdata[63:0], reg at 8*i
//
// one line byte leaves per cycle through a single output register unless
// out_ready stalls; an item is taken only while the sequencer is idle, then
// its bytes go out one a cycle: for an opening byte the flag, 19 header bytes
// and the byte; else the byte, then on a closing byte crc-32 (if on) and flag
// reset (rst_n, async low) clears the sequencer, scrambler, crc and run count
// a stall on out_ready freezes the sequencer with the pending byte held

`default_nettype none

module packet_framer_scramble_crc_stuff
    import pfs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input transactions
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            payload_byte,
    input  wire logic                  last_of_frame,
    // output transactions
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [9:0]            line_bits,
    output logic      [3:0]            bit_count,
    output logic                       frame_done,
    // register port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    // register file contents
    cfg_t  cfg;
    // sequencer commands and datapath status
    cmd_t  cmd;
    stat_t stat;

    pfs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: flag, 19 header bytes, payload, optional crc, closing flag
    pfs_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .last_of_frame (last_of_frame),
        .crc_enable    (cfg.crc_enable),
        .stat          (stat),
        .cmd           (cmd)
    );

    // byte mux, scrambler, crc-32, zero stuffing and output register
    pfs_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .payload_byte (payload_byte),
        .cfg          (cfg),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .line_bits    (line_bits),
        .bit_count    (bit_count),
        .frame_done   (frame_done)
    );

endmodule

`default_nettype wire

### hw/rtl/pfs_checker.sv
`default_nettype none

module pfs_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [9:0] line_bits,
    input wire logic [3:0] bit_count,
    input wire logic       frame_done
);

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(line_bits)
            && $stable(bit_count) && $stable(frame_done))
        else $error("output transaction changed while stalled");

    // stuffing never grows a byte past ten bits
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> bit_count == 4'd8 || bit_count == 4'd9 || bit_count == 4'd10)
        else $error("bit_count out of range");

    // closing group is the raw flag
    a_done_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> line_bits == 10'h07E && bit_count == 4'd8)
        else $error("closing group is not a raw flag");

    // bits above the count are zero
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bit_count != 4'd10 |-> line_bits[9] == 1'b0
            && (bit_count != 4'd8 || line_bits[8] == 1'b0))
        else $error("unused line bits not zero");

endmodule

bind packet_framer_scramble_crc_stuff pfs_checker u_pfs_checker (.*);

`default_nettype wire

### tb/pfs_line_checker.sv
`timescale 1ns / 1ps

module pfs_line_checker
    import pfs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic [7:0]            payload_byte,
    input  wire logic                  last_of_frame,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [9:0]            line_bits,
    input  wire logic [3:0]            bit_count,
    input  wire logic                  frame_done,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic                  pready,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output int                         mismatches,
    output int                         groups_pending
);

    localparam logic [7:0] PREAMBLE = 8'h55;
    localparam logic [7:0] SYNC_0   = 8'hF1;
    localparam logic [7:0] SYNC_1   = 8'h5E;
    localparam logic [7:0] SYNC_2   = 8'h48;

    typedef struct packed {
        logic [9:0] bits;
        logic [3:0] count;
        logic       done;
    } line_group_t;

    line_group_t groups_due[$];
    cfg_t        regs;
    logic        frame_open;
    logic [4:0]  scr_state;
    logic [31:0] crc_acc;
    logic [2:0]  one_streak;

    function automatic void queue_group(input logic [9:0] bits, input logic [3:0] count,
                                        input logic done);
        line_group_t g;
        g.bits = bits;
        g.count = count;
        g.done = done;
        groups_due = {groups_due, g};
    endfunction

    // flags go out raw, msb first
    function automatic void queue_flag(input logic done);
        logic [9:0] bits;
        bits = '0;
        for (int i = 0; i < 8; i++)
            bits[i] = FLAG_BYTE[7 - i];
        queue_group(bits, 4'd8, done);
    endfunction

    // msb first, a zero after every run of five ones
    function automatic void queue_stuffed(input logic [7:0] b);
        logic [9:0] bits;
        int         pos;
        bits = '0;
        pos = 0;
        for (int i = 7; i >= 0; i--)
        begin
            bits[pos] = b[i];
            pos++;
            if (b[i])
            begin
                one_streak++;
                if (one_streak >= 3'd5)
                begin
                    pos++;
                    one_streak = '0;
                end
            end
            else
            begin
                one_streak = '0;
            end
        end
        queue_group(bits, 4'(pos), 1'b0);
    endfunction

    function automatic void crc_feed(input logic [7:0] b);
        crc_acc ^= {24'h0, b};
        for (int j = 0; j < 8; j++)
            crc_acc = crc_acc[0] ? ((crc_acc >> 1) ^ CRC_POLY) : (crc_acc >> 1);
    endfunction

    function automatic logic [7:0] scramble_byte(input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb = scr_state[4] ^ scr_state[0];
            scr_state = {scr_state[3:0], fb};
            r[i] = b[i] ^ fb;
        end
        return r;
    endfunction

    function automatic void queue_header(input logic [7:0] b);
        crc_feed(b);
        queue_stuffed(b);
    endfunction

    function automatic void queue_address(input logic [47:0] call, input logic [3:0] ssid,
                                          input logic is_src);
        for (int i = 0; i < 6; i++)
            queue_header({call[40 - 8 * i +: 7], 1'b0});
        queue_header({3'b000, ssid, is_src});
    endfunction

    function automatic void predict_line_groups(input logic [7:0] b, input logic last);
        logic [7:0]  s;
        logic [31:0] c;
        logic        closes;
        closes = last;
        if (!frame_open)
        begin
            frame_open = 1'b1;
            scr_state = SCR_INIT;
            crc_acc = CRC_INIT;
            one_streak = '0;
            queue_flag(1'b0);
            queue_header(PREAMBLE);
            queue_header(SYNC_0);
            queue_header(SYNC_1);
            queue_header(SYNC_2);
            queue_header(regs.fec_code);
            queue_address(regs.dst_call, regs.dst_sub_id, 1'b0);
            queue_address(regs.org_call, regs.org_sub_id, 1'b1);
            // a mark on the opening byte does not close the frame
            closes = 1'b0;
        end
        s = scramble_byte(b);
        crc_feed(s);
        queue_stuffed(s);
        if (closes)
        begin
            if (regs.crc_enable)
            begin
                c = crc_acc ^ CRC_INIT;
                for (int i = 0; i < 4; i++)
                    queue_stuffed(c[8 * i +: 8]);
            end
            queue_flag(1'b1);
            frame_open = 1'b0;
            one_streak = '0;
            scr_state = SCR_INIT;
            crc_acc = CRC_INIT;
        end
    endfunction

    function automatic void write_reg(input logic [REG_IDX_W-1:0] idx,
                                      input logic [APB_DATA_W-1:0] value);
        case (idx)
            REG_FEC_CODE:   regs.fec_code = value[7:0];
            REG_CRC_ENABLE: regs.crc_enable = value[0];
            REG_DST_CALL:   regs.dst_call = value[47:0];
            REG_DST_SUB_ID: regs.dst_sub_id = value[3:0];
            REG_ORG_CALL:   regs.org_call = value[47:0];
            REG_ORG_SUB_ID: regs.org_sub_id = value[3:0];
            default:        ;
        endcase
    endfunction

    function automatic void note_mismatch(input string what, input line_group_t want,
                                          input line_group_t got);
        if (mismatches < 10)
            $display("%0t %s: expected bits %03h count %0d done %0b, got bits %03h count %0d done %0b",
                     $time, what, want.bits, want.count, want.done,
                     got.bits, got.count, got.done);
        mismatches++;
    endfunction

    always @(posedge clk)
    begin
        line_group_t want;
        line_group_t got;
        if (!rst_n)
        begin
            regs.fec_code = '0;
            regs.crc_enable = 1'b1;
            regs.dst_call = CALLSIGN_RESET;
            regs.dst_sub_id = '0;
            regs.org_call = CALLSIGN_RESET;
            regs.org_sub_id = '0;
            frame_open = 1'b0;
            scr_state = SCR_INIT;
            crc_acc = CRC_INIT;
            one_streak = '0;
            groups_due.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                write_reg(paddr[APB_ADDR_W-1 -: REG_IDX_W], pwdata);
            if (in_valid && in_ready)
                predict_line_groups(payload_byte, last_of_frame);
            if (out_valid && out_ready)
            begin
                got.bits = line_bits;
                got.count = bit_count;
                got.done = frame_done;
                if (groups_due.size() == 0)
                begin
                    note_mismatch("line group with nothing pending", '0, got);
                end
                else
                begin
                    want = groups_due.pop_front();
                    if (got.bits !== want.bits || got.count !== want.count ||
                        got.done !== want.done)
                        note_mismatch("line group mismatch", want, got);
                end
            end
        end
        groups_pending = groups_due.size();
    end

endmodule

### tb/packet_framer_scramble_crc_stuff_tb.sv
`timescale 1ns / 1ps

module packet_framer_scramble_crc_stuff_tb;
    import pfs_pkg::*;

    // run bounds
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 40;

    // register slots past the end of the map, writes there must be ignored
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            payload_byte;
    logic                  last_of_frame;
    logic                  out_valid;
    logic                  out_ready;
    logic [9:0]            line_bits;
    logic [3:0]            bit_count;
    logic                  frame_done;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int   mismatches;
    int   groups_pending;
    int   cycle_count = 0;
    int   items_sent = 0;
    int   sender_idle_pct = 0;
    int   receiver_idle_pct = 0;
    logic hold_request = 1'b0;
    logic hold_done = 1'b0;

    packet_framer_scramble_crc_stuff u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .payload_byte  (payload_byte),
        .last_of_frame (last_of_frame),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .line_bits     (line_bits),
        .bit_count     (bit_count),
        .frame_done    (frame_done),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // the checker mirrors register writes, predicts line groups and compares
    pfs_line_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .payload_byte   (payload_byte),
        .last_of_frame  (last_of_frame),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .line_bits      (line_bits),
        .bit_count      (bit_count),
        .frame_done     (frame_done),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatches     (mismatches),
        .groups_pending (groups_pending)
    );

    // 2 ns clock, low for the first half period
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("packet_framer_scramble_crc_stuff_tb failed");
            $finish;
        end
    end

    // output side: random back-pressure, plus one long hold-off when asked;
    // during the hold-off the sender keeps offering so the block backs up
    initial
    begin : receiver
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // every task below is entered right after a falling edge at which
    // none of its signals has been assigned yet

    // setup cycle, then access cycle; the write lands at the edge with pready
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, {(APB_ADDR_W - REG_IDX_W){1'b0}}};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    // one input transaction, with random idle cycles ahead of it
    task automatic send_item(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        payload_byte <= b;
        last_of_frame <= last;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        items_sent++;
    endtask

    // drop valid, then wait until every predicted group has left the block
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (groups_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // payload bytes lean toward all ones and all zeros to hit stuffing runs
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'hFF;
            1:       return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [APB_DATA_W-1:0] pick_callsign();
        case ($urandom_range(3))
            0:       return '1;
            1:       return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // full-width random data, so bits above each register's width get dropped
    task automatic random_config();
        write_reg(REG_FEC_CODE, {$urandom, $urandom});
        write_reg(REG_CRC_ENABLE, {$urandom, $urandom});
        write_reg(REG_DST_CALL, pick_callsign());
        write_reg(REG_DST_SUB_ID, {$urandom, $urandom});
        write_reg(REG_ORG_CALL, pick_callsign());
        write_reg(REG_ORG_SUB_ID, {$urandom, $urandom});
    endtask

    // a frame closes on its last byte; now and then the opening byte also
    // carries a mark, which the block must ignore
    task automatic send_frame(input int len, input logic mark_opening);
        for (int i = 0; i < len; i++)
            send_item(pick_byte(), (i == len - 1) || (mark_opening && i == 0));
    endtask

    // two settings per phase, each followed by a full drain
    task automatic run_phase(input int quota, input int send_pct, input int recv_pct);
        int first;
        sender_idle_pct = send_pct;
        receiver_idle_pct <= recv_pct;
        for (int part = 0; part < 2; part++)
        begin
            random_config();
            first = items_sent;
            while (items_sent - first < quota / 2)
                send_frame($urandom_range(2, 10), $urandom_range(7) == 0);
            wait_drained();
        end
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        in_valid = 1'b0;
        payload_byte = '0;
        last_of_frame = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: short frame of all-zero and all-one bytes
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        // mark on the opening byte is ignored, the next marked byte closes
        send_item(8'hA5, 1'b1);
        send_item(8'h5A, 1'b1);
        wait_drained();

        // extremes: no checksum, all-ones and all-zero addresses, top ssids
        write_reg(REG_FEC_CODE, '1);
        write_reg(REG_CRC_ENABLE, 64'hFFFF_FFFF_FFFF_FFFE);
        write_reg(REG_DST_CALL, '1);
        write_reg(REG_DST_SUB_ID, '1);
        write_reg(REG_ORG_CALL, '0);
        write_reg(REG_ORG_SUB_ID, '1);
        write_reg(REG_UNMAPPED_LO, '1);
        write_reg(REG_UNMAPPED_HI, {$urandom, $urandom});
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h01, 1'b1);
        wait_drained();

        // ordinary addresses with the checksum back on; payload holds flag
        // patterns and long runs of ones
        write_reg(REG_FEC_CODE, '0);
        write_reg(REG_CRC_ENABLE, 64'h1);
        write_reg(REG_DST_CALL, 64'h0000_5445_5354_3120);
        write_reg(REG_DST_SUB_ID, '0);
        write_reg(REG_ORG_CALL, 64'h0000_4E4F_4445_3220);
        write_reg(REG_ORG_SUB_ID, 64'h7);
        send_item(8'h7E, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h3F, 1'b0);
        send_item(8'hFC, 1'b0);
        send_item(8'h55, 1'b1);
        wait_drained();

        // random part: slow sender and slower receiver, then swapped,
        // then full rate with one long output hold-off
        run_phase(42, 31, 81);
        run_phase(42, 81, 31);
        hold_request <= 1'b1;
        run_phase(44, 0, 0);

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && groups_pending == 0)
            $display("packet_framer_scramble_crc_stuff_tb passed");
        else
            $display("packet_framer_scramble_crc_stuff_tb failed");
        $finish;
    end

endmodule
